>>> hw/rtl/tpbc_pkg.sv
// Shared types, constants and checksum helpers for the TCP blank and checksum unit.
package tpbc_pkg;

    localparam int MAX_SEGMENT = 2048;
    localparam int IDX_W       = $clog2(MAX_SEGMENT) + 1;
    localparam int SUM_W       = 17;
    localparam int HDR_W       = 6;
    localparam int LIMIT_W     = 6;

    localparam logic [LIMIT_W-1:0] BLANK_LIMIT_RESET = 6'd30;
    localparam logic [HDR_W-1:0]   MIN_HDR_BYTES     = 6'd20;
    localparam logic [IDX_W-1:0]   IDX_SEG_MAX       = IDX_W'(MAX_SEGMENT);
    localparam logic [IDX_W-1:0]   IDX_DATA_OFFSET   = IDX_W'(12);
    localparam logic [IDX_W-1:0]   IDX_CHECK_HI      = IDX_W'(16);
    localparam logic [IDX_W-1:0]   IDX_CHECK_LO      = IDX_W'(17);
    localparam logic [15:0]        TCP_PROTOCOL      = 16'd6;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [SUM_W-1:0] sum;
        logic [7:0]       held;
        logic [HDR_W-1:0] hdr;
        logic             bad;
    } seg_state_t;

    typedef struct packed {
        logic [7:0]       seg_byte;
        logic             seg_last;
        logic [SUM_W-1:0] ph_sum;
    } item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_last;
        logic [15:0] checksum;
        logic        too_long;
        logic        bad_header_length;
    } result_t;

    function automatic logic [SUM_W-1:0] oc_add(input logic [SUM_W-1:0] s,
                                                input logic [15:0] w);
        logic [SUM_W:0] t;
        t = {1'b0, s} + {2'b00, w};
        return {1'b0, t[15:0]} + {15'b0, t[17:16]};
    endfunction

    function automatic logic [SUM_W-1:0] pseudo_sum(input logic [31:0] src,
                                                    input logic [31:0] dst);
        logic [SUM_W-1:0] s;
        s = oc_add('0, src[31:16]);
        s = oc_add(s, src[15:0]);
        s = oc_add(s, dst[31:16]);
        s = oc_add(s, dst[15:0]);
        s = oc_add(s, TCP_PROTOCOL);
        return s;
    endfunction

endpackage

>>> hw/rtl/tpbc_step.sv
// Per-byte blanking, byte pairing and checksum finish for one segment item.
module tpbc_step (
    input  tpbc_pkg::item_t                    item,
    input  tpbc_pkg::seg_state_t               st,
    input  logic [tpbc_pkg::LIMIT_W-1:0]       blank_limit,
    output tpbc_pkg::seg_state_t               st_next,
    output tpbc_pkg::result_t                  res
);

    logic [tpbc_pkg::IDX_W-1:0] idx;
    logic [tpbc_pkg::IDX_W-1:0] count;
    logic [tpbc_pkg::IDX_W-1:0] hdr_ext;
    logic [tpbc_pkg::SUM_W-1:0] base;
    logic [tpbc_pkg::SUM_W-1:0] sum_new;
    logic [tpbc_pkg::SUM_W-1:0] padded;
    logic [tpbc_pkg::SUM_W-1:0] final_sum;
    logic [tpbc_pkg::HDR_W-1:0] hdr_new;
    logic                       bad_new;
    logic                       blank;
    logic                       too;
    logic [7:0]                 ob;
    logic [7:0]                 cb;
    logic [7:0]                 held_new;

    always_comb
    begin
        idx     = st.idx;
        hdr_ext = {{(tpbc_pkg::IDX_W-tpbc_pkg::HDR_W){1'b0}}, st.hdr};
        base    = (idx == '0) ? item.ph_sum : st.sum;

        blank = (idx > tpbc_pkg::IDX_DATA_OFFSET) && !st.bad && (idx >= hdr_ext) &&
                ((idx - hdr_ext) <
                 {{(tpbc_pkg::IDX_W-tpbc_pkg::LIMIT_W){1'b0}}, blank_limit});
        ob = blank ? 8'h00 : item.seg_byte;
        cb = (idx == tpbc_pkg::IDX_CHECK_HI || idx == tpbc_pkg::IDX_CHECK_LO) ? 8'h00 : ob;

        if (idx[0])
        begin
            sum_new  = tpbc_pkg::oc_add(base, {st.held, cb});
            held_new = st.held;
        end
        else
        begin
            sum_new  = base;
            held_new = cb;
        end

        if (idx == tpbc_pkg::IDX_DATA_OFFSET)
        begin
            hdr_new = {item.seg_byte[7:4], 2'b00};
            bad_new = ({item.seg_byte[7:4], 2'b00} < tpbc_pkg::MIN_HDR_BYTES);
        end
        else
        begin
            hdr_new = st.hdr;
            bad_new = st.bad;
        end

        count = (idx == tpbc_pkg::IDX_SEG_MAX) ? idx : idx + tpbc_pkg::IDX_W'(1);

        padded    = idx[0] ? sum_new : tpbc_pkg::oc_add(sum_new, {held_new, 8'h00});
        final_sum = tpbc_pkg::oc_add(padded, 16'(count));
        too       = (count == tpbc_pkg::IDX_SEG_MAX);

        if (item.seg_last)
        begin
            st_next = '0;
        end
        else
        begin
            st_next.idx  = count;
            st_next.sum  = sum_new;
            st_next.held = held_new;
            st_next.hdr  = hdr_new;
            st_next.bad  = bad_new;
        end

        res.out_byte          = ob;
        res.out_last          = item.seg_last;
        res.checksum          = (item.seg_last && !too) ? ~final_sum[15:0] : 16'h0000;
        res.too_long          = item.seg_last && too;
        res.bad_header_length = bad_new;
    end

endmodule

>>> hw/rtl/tcp_payload_blank_and_checksum_unit.sv
// Top level of the TCP payload blank and checksum unit.
//
// Segment bytes enter on the in_valid/in_ready channel, header first, one item
// per byte, with seg_last on the final byte; src_addr and dst_addr are taken
// with the first byte of each segment. Each item yields one result item on the
// out_valid/out_ready channel: the byte (zeroed inside the payload window),
// out_last, bad_header_length, and on the final byte the TCP checksum and the
// too_long flag. From acceptance the item sits in the input register, then the
// per-byte step logic loads the result register, which drives out_valid. Throughput
// is one item per cycle while the receiver does not stall; the loop through the
// segment state register sets that figure. When the receiver stalls the result
// register holds, the input register fills, and in_ready then drops until out_ready
// returns. blank_limit is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while idle, as the block does not enforce it. Reset empties both
// registers, clears the segment state and sets blank_limit to 30.
module tcp_payload_blank_and_checksum_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [tpbc_pkg::LIMIT_W-1:0]  cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    seg_byte,
    input  logic [31:0]                   src_addr,
    input  logic [31:0]                   dst_addr,
    input  logic                          seg_last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    out_byte,
    output logic                          out_last,
    output logic [15:0]                   checksum,
    output logic                          too_long,
    output logic                          bad_header_length
);

    logic [tpbc_pkg::LIMIT_W-1:0] limit_reg;
    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    tpbc_pkg::item_t              s1_item_reg;
    tpbc_pkg::item_t              s1_item_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    tpbc_pkg::result_t            out_reg;
    tpbc_pkg::seg_state_t         state_reg;
    tpbc_pkg::seg_state_t         state_next;
    tpbc_pkg::result_t            step_res;
    logic                         advance;
    logic                         fire;
    logic                         in_take;

    assign advance  = !out_valid_reg || out_ready;
    assign fire     = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        s1_item_next.seg_byte = seg_byte;
        s1_item_next.seg_last = seg_last;
        s1_item_next.ph_sum   = tpbc_pkg::pseudo_sum(src_addr, dst_addr);

        if (in_take)
            s1_valid_next = 1'b1;
        else if (fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    tpbc_step u_step (
        .item        (s1_item_reg),
        .st          (state_reg),
        .blank_limit (limit_reg),
        .st_next     (state_next),
        .res         (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= tpbc_pkg::BLANK_LIMIT_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_item_reg <= s1_item_next;
        if (fire)
            out_reg <= step_res;
    end

    assign out_valid         = out_valid_reg;
    assign out_byte          = out_reg.out_byte;
    assign out_last          = out_reg.out_last;
    assign checksum          = out_reg.checksum;
    assign too_long          = out_reg.too_long;
    assign bad_header_length = out_reg.bad_header_length;

endmodule
